### hw/rtl/pcwc_pkg.sv
// ----------------------------------------------------------------------------
// pcwc_pkg
// Shared types, constants and helper functions of the pixel colour window
// classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package pcwc_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int YQ_W       = 24;
  localparam int PROD_W     = 24;
  localparam int CHROMA_W   = 42;

  // Q16 color conversion coefficients.
  localparam logic [15:0] COEF_YR = 16'd19595;
  localparam logic [15:0] COEF_YG = 16'd38470;
  localparam logic [15:0] COEF_YB = 16'd7471;
  localparam logic [15:0] COEF_CR = 16'd46727;
  localparam logic [15:0] COEF_CB = 16'd36962;

  localparam logic [CFG_DATA_W-1:0] WINDOW_RESET    = 16'hFF00;
  localparam logic [CFG_DATA_W-1:0] GAIN_LOW_RESET  = 16'h0000;
  localparam logic [CFG_DATA_W-1:0] GAIN_HIGH_RESET = 16'h0100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE            = 3'd0,
    REG_LUMA_WINDOW     = 3'd1,
    REG_CR_WINDOW       = 3'd2,
    REG_CB_WINDOW       = 3'd3,
    REG_GREEN_GAIN_LOW  = 3'd4,
    REG_GREEN_GAIN_HIGH = 3'd5,
    REG_BLUE_GAIN_LOW   = 3'd6,
    REG_BLUE_GAIN_HIGH  = 3'd7
  } cfg_idx_t;

  typedef enum logic {
    MODE_YCC   = 1'b0,
    MODE_RATIO = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                 mode;
    logic [CFG_DATA_W-1:0] luma_window;
    logic [CFG_DATA_W-1:0] cr_window;
    logic [CFG_DATA_W-1:0] cb_window;
    logic [CFG_DATA_W-1:0] green_gain_low;
    logic [CFG_DATA_W-1:0] green_gain_high;
    logic [CFG_DATA_W-1:0] blue_gain_low;
    logic [CFG_DATA_W-1:0] blue_gain_high;
  } cfg_t;

  // Valid bits of the three pipeline stages.
  typedef struct packed {
    logic a;
    logic b;
    logic c;
  } occ_t;

  // Takes the integer part of a biased Q32 chroma value and clamps it to a byte.
  function automatic logic [PIX_W-1:0] sat_chroma(input logic signed [CHROMA_W-1:0] v);
    logic [PIX_W-1:0] res;
    if (v[CHROMA_W-1]) begin
      res = '0;
    end else if (v[CHROMA_W-2:CHROMA_W-2] != 1'b0) begin
      res = '1;
    end else begin
      res = v[39:32];
    end
    return res;
  endfunction

  // Inclusive window test: high byte is the maximum, low byte the minimum.
  function automatic logic in_window(input logic [PIX_W-1:0] v,
                                     input logic [CFG_DATA_W-1:0] win);
    return (v >= win[7:0]) && (v <= win[15:8]);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/pcwc_cfg.sv
// ----------------------------------------------------------------------------
// pcwc_cfg
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module pcwc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pcwc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcwc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output pcwc_pkg::cfg_t                   cfg
);
  import pcwc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode            <= MODE_YCC;
      cfg.luma_window     <= WINDOW_RESET;
      cfg.cr_window       <= WINDOW_RESET;
      cfg.cb_window       <= WINDOW_RESET;
      cfg.green_gain_low  <= GAIN_LOW_RESET;
      cfg.green_gain_high <= GAIN_HIGH_RESET;
      cfg.blue_gain_low   <= GAIN_LOW_RESET;
      cfg.blue_gain_high  <= GAIN_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_MODE:            cfg.mode            <= mode_t'(cfg_data[0]);
        REG_LUMA_WINDOW:     cfg.luma_window     <= cfg_data;
        REG_CR_WINDOW:       cfg.cr_window       <= cfg_data;
        REG_CB_WINDOW:       cfg.cb_window       <= cfg_data;
        REG_GREEN_GAIN_LOW:  cfg.green_gain_low  <= cfg_data;
        REG_GREEN_GAIN_HIGH: cfg.green_gain_high <= cfg_data;
        REG_BLUE_GAIN_LOW:   cfg.blue_gain_low   <= cfg_data;
        REG_BLUE_GAIN_HIGH:  cfg.blue_gain_high  <= cfg_data;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pcwc_pipe.sv
// ----------------------------------------------------------------------------
// pcwc_pipe
// Three-stage classification pipeline: products, chroma scaling and ratio
// compares, then saturation, window tests and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcwc_pipe (
  input  logic                        clk,
  input  logic                        rst,
  input  pcwc_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pcwc_pkg::PIX_W-1:0]  red,
  input  logic [pcwc_pkg::PIX_W-1:0]  green,
  input  logic [pcwc_pkg::PIX_W-1:0]  blue,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        is_marker,
  output pcwc_pkg::occ_t              occ
);
  import pcwc_pkg::*;

  logic ready_a;
  logic ready_b;
  logic ready_c;
  logic valid_a;
  logic valid_b;

  // Stage A registers.
  logic [PIX_W-1:0]  red_a;
  logic [PIX_W-1:0]  green_a;
  logic [PIX_W-1:0]  blue_a;
  logic [YQ_W-1:0]   yq_a;
  logic [PROD_W-1:0] glo_a;
  logic [PROD_W-1:0] ghi_a;
  logic [PROD_W-1:0] blo_a;
  logic [PROD_W-1:0] bhi_a;
  logic [YQ_W-1:0]   yq_next;

  // Stage B registers.
  logic [PIX_W-1:0]           luma_b;
  logic signed [CHROMA_W-1:0] cr_b;
  logic signed [CHROMA_W-1:0] cb_b;
  logic                       ratio_b;
  logic signed [24:0]         dr;
  logic signed [24:0]         db;
  logic signed [CHROMA_W-1:0] cr_next;
  logic signed [CHROMA_W-1:0] cb_next;
  logic [PROD_W-1:0]          green_s;
  logic [PROD_W-1:0]          blue_s;
  logic                       ratio_next;

  // Stage C logic.
  logic signed [CHROMA_W-1:0] bias;
  logic [PIX_W-1:0]           cr_sat;
  logic [PIX_W-1:0]           cb_sat;
  logic                       ycc_hit;

  assign ready_c  = !out_valid || out_ready;
  assign ready_b  = !valid_b || ready_c;
  assign ready_a  = !valid_a || ready_b;
  assign in_ready = ready_a;
  assign occ      = '{a: valid_a, b: valid_b, c: out_valid};

  assign yq_next = YQ_W'(COEF_YR) * YQ_W'(red) + YQ_W'(COEF_YG) * YQ_W'(green)
                 + YQ_W'(COEF_YB) * YQ_W'(blue);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (ready_a) begin
      valid_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ready_a) begin
      red_a   <= red;
      green_a <= green;
      blue_a  <= blue;
      yq_a    <= yq_next;
      glo_a   <= PROD_W'(cfg.green_gain_low) * PROD_W'(red);
      ghi_a   <= PROD_W'(cfg.green_gain_high) * PROD_W'(red);
      blo_a   <= PROD_W'(cfg.blue_gain_low) * PROD_W'(red);
      bhi_a   <= PROD_W'(cfg.blue_gain_high) * PROD_W'(red);
    end
  end

  assign dr = $signed({1'b0, red_a, 16'h0000}) - $signed({1'b0, yq_a});
  assign db = $signed({1'b0, blue_a, 16'h0000}) - $signed({1'b0, yq_a});
  assign cr_next = CHROMA_W'(dr) * CHROMA_W'($signed({1'b0, COEF_CR}));
  assign cb_next = CHROMA_W'(db) * CHROMA_W'($signed({1'b0, COEF_CB}));

  assign green_s = PROD_W'({green_a, 8'h00});
  assign blue_s  = PROD_W'({blue_a, 8'h00});
  assign ratio_next = (green_s < ghi_a) && (green_s > glo_a)
                   && (blue_s < bhi_a) && (blue_s > blo_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else if (ready_b) begin
      valid_b <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_a && ready_b) begin
      luma_b  <= yq_a[YQ_W-1:16];
      cr_b    <= cr_next;
      cb_b    <= cb_next;
      ratio_b <= ratio_next;
    end
  end

  assign bias    = CHROMA_W'(128) <<< 32;
  assign cr_sat  = sat_chroma(cr_b + bias);
  assign cb_sat  = sat_chroma(cb_b + bias);
  assign ycc_hit = in_window(luma_b, cfg.luma_window) && in_window(cr_sat, cfg.cr_window)
                && in_window(cb_sat, cfg.cb_window);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_c) begin
      out_valid <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_b && ready_c) begin
      is_marker <= (cfg.mode == MODE_RATIO) ? ratio_b : ycc_hit;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pixel_colour_window_classifier_core.sv
// ----------------------------------------------------------------------------
// pixel_colour_window_classifier_core
// Marks RGB pixels that match a configured colour by YCbCr windows or by
// green and blue to red ratio bands.
// ----------------------------------------------------------------------------
// One pixel is accepted every clock while the output is not stalled. The rate
// is one word per cycle under the same condition. Each pixel is registered in
// the three register stages of the classification pipeline: products, chroma
// scaling, and window tests with the output register. Every pipeline
// stage has its own valid bit, so a stall at the output only holds back as
// many stages as are full. Registers are written through cfg_we, cfg_index
// and cfg_data and should change only while no word is in flight.
`default_nettype none

module pixel_colour_window_classifier_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] is_marker, [7:1] zero
  input  logic                             cfg_we,
  input  logic [pcwc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcwc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pcwc_pkg::*;

  cfg_t cfg;
  occ_t occ;
  logic is_marker;
  logic in_acc;
  logic out_acc;

  pcwc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcwc_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .red       (s_tdata[7:0]),
    .green     (s_tdata[15:8]),
    .blue      (s_tdata[23:16]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .is_marker (is_marker),
    .occ       (occ)
  );

  assign m_tdata = {7'b0, is_marker};
  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // A free stage anywhere in the pipeline must let a new word in.
  assert property (@(posedge clk) disable iff (rst)
    (!occ.a || !occ.b || !occ.c) |-> s_tready)
    else $error("input stalled although a pipeline stage is free");

  // Words in flight change only by what enters and what leaves.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (3'($countones(occ)) + 3'($past(out_acc))
                    == 3'($countones($past(occ))) + 3'($past(in_acc))))
    else $error("pipeline lost or duplicated a word");

  // The output stage holds a word in the cycle after the middle stage was
  // full and the output was not taken.
  assert property (@(posedge clk) disable iff (rst)
    (occ.b && !m_tready) |=> m_tvalid)
    else $error("output stage empty after a stalled full stage");

endmodule

`default_nettype wire
